/* design/ssm_pkg.sv */
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types and constants for the screen selection marker.
// ----------------------------------------------------------------------------
package ssm_pkg;

  // Default depth of the selection bitmap
  localparam int MaxCellsDef = 8192;

  // Configuration register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // Geometry limits
  localparam logic [6:0] RowsReset = 7'd24;
  localparam logic [7:0] ColsReset = 8'd80;
  localparam logic [6:0] RowsMax   = 7'd64;
  localparam logic [7:0] ColsMax   = 8'd128;

  typedef enum logic [1:0] {
    REQ_SELECT,
    REQ_MODE,
    REQ_FLAGS,
    REQ_BOX
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE,
    ST_OUT_OF_SCREEN,
    ST_NO_SEL,
    ST_UNCHANGED
  } status_e;

  // What the request needs after its checks
  typedef enum logic [1:0] {
    DEC_FINISH,
    DEC_REDRAW,
    DEC_PROBE,
    DEC_BOX
  } dec_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_GEOM,
    S_DECIDE,
    S_LOCATE,
    S_SWEEP,
    S_DRAIN,
    S_PROBE,
    S_PWAIT,
    S_FINISH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic take;
    logic geom;
    logic decide;
    logic locate;
    logic sweep;
    logic probe_issue;
    logic probe_cap;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    dec_e dec;
    logic geom_over;
    logic loc_done;
    logic sweep_last;
    logic clear_last;
    logic probe_last;
    logic out_free;
  } sts_t;

endpackage

/* design/ssm_ctrl.sv */
// ----------------------------------------------------------------------------
// ssm_ctrl
// Sequencer: clearing pass, geometry fit, checks, locate, sweep, probes.
// ----------------------------------------------------------------------------
module ssm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ssm_pkg::sts_t sts_i,
  output ssm_pkg::cmd_t cmd_o
);

  ssm_pkg::state_e state_q, state_d;
  ssm_pkg::dec_e   kind_q;

  // State and request kind registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssm_pkg::S_CLEAR;
      kind_q  <= ssm_pkg::DEC_FINISH;
    end else begin
      state_q <= state_d;
      if (state_q == ssm_pkg::S_DECIDE) begin
        kind_q <= sts_i.dec;
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssm_pkg::S_CLEAR:  if (sts_i.clear_last) state_d = ssm_pkg::S_IDLE;
      ssm_pkg::S_IDLE:   if (in_valid_i) state_d = ssm_pkg::S_GEOM;
      ssm_pkg::S_GEOM:   if (!sts_i.geom_over) state_d = ssm_pkg::S_DECIDE;
      ssm_pkg::S_DECIDE: begin
        unique case (sts_i.dec)
          ssm_pkg::DEC_FINISH: state_d = ssm_pkg::S_FINISH;
          ssm_pkg::DEC_REDRAW: state_d = ssm_pkg::S_LOCATE;
          ssm_pkg::DEC_PROBE:  state_d = ssm_pkg::S_LOCATE;
          ssm_pkg::DEC_BOX:    state_d = ssm_pkg::S_SWEEP;
          default:             state_d = ssm_pkg::S_FINISH;
        endcase
      end
      ssm_pkg::S_LOCATE: begin
        if (sts_i.loc_done) begin
          state_d = (kind_q == ssm_pkg::DEC_PROBE) ? ssm_pkg::S_PROBE : ssm_pkg::S_SWEEP;
        end
      end
      ssm_pkg::S_SWEEP:  if (sts_i.sweep_last) state_d = ssm_pkg::S_DRAIN;
      ssm_pkg::S_DRAIN:  state_d = ssm_pkg::S_FINISH;
      ssm_pkg::S_PROBE:  state_d = ssm_pkg::S_PWAIT;
      ssm_pkg::S_PWAIT:  state_d = sts_i.probe_last ? ssm_pkg::S_FINISH : ssm_pkg::S_PROBE;
      ssm_pkg::S_FINISH: if (sts_i.out_free) state_d = ssm_pkg::S_IDLE;
      default:           state_d = ssm_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ssm_pkg::S_CLEAR:  cmd_o.clear = 1'b1;
      ssm_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ssm_pkg::S_GEOM:   cmd_o.geom = 1'b1;
      ssm_pkg::S_DECIDE: cmd_o.decide = 1'b1;
      ssm_pkg::S_LOCATE: cmd_o.locate = 1'b1;
      ssm_pkg::S_SWEEP:  cmd_o.sweep = 1'b1;
      ssm_pkg::S_DRAIN:  cmd_o = '0;
      ssm_pkg::S_PROBE:  cmd_o.probe_issue = 1'b1;
      ssm_pkg::S_PWAIT:  cmd_o.probe_cap = 1'b1;
      ssm_pkg::S_FINISH: cmd_o.finish = sts_i.out_free;
      default:           cmd_o = '0;
    endcase
  end

endmodule

/* design/ssm_datapath.sv */
// ----------------------------------------------------------------------------
// ssm_datapath
// Selection bitmap, geometry, address locators, sweep pipe and result reg.
// ----------------------------------------------------------------------------
module ssm_datapath #(
  parameter int MAX_CELLS = ssm_pkg::MaxCellsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ssm_pkg::cmd_t cmd_i,
  output ssm_pkg::sts_t sts_o,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [7:0]    cfg_data_i,
  input  logic [1:0]    req_type_i,
  input  logic [12:0]   start_addr_i,
  input  logic [12:0]   end_addr_i,
  input  logic          rect_mode_i,
  input  logic [12:0]   cell_addr_i,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic [1:0]    status_o,
  output logic [13:0]   changed_count_o,
  output logic [6:0]    cell_flags_o,
  output logic [5:0]    box_row_o,
  output logic [6:0]    box_col_o,
  output logic [7:0]    box_width_o,
  output logic [6:0]    box_height_o
);

  localparam int AW  = $clog2(MAX_CELLS);
  localparam int AXW = (AW > 13) ? AW : 13;

  // Configuration
  logic [6:0] rows_cfg_q;
  logic [7:0] cols_cfg_q;

  // Request
  ssm_pkg::req_e req_q;
  logic [12:0] sa_q, ea_q, ca_q;
  logic        rm_q;

  // Geometry
  logic [6:0]  g_rows_q;
  logic [7:0]  g_cols_q;
  logic [13:0] len_q;
  logic [14:0] prod;

  // Selection state
  logic [12:0] anchor_q, final_q;
  logic        has_sel_q, rect_q;

  // Locators: anchor, final, queried cell
  logic [12:0] la_rem_q, la_quo_q, lb_rem_q, lb_quo_q, lx_rem_q, lx_quo_q;
  logic [12:0] cols_x;
  logic        ga, gb, gx;

  // Sweep pipe
  logic [5:0]    sw_r_q, p_r_q;
  logic [6:0]    sw_c_q, p_c_q;
  logic [AW-1:0] sw_a_q, p_a_q;
  logic          p_valid_q;
  logic [6:0]    rows_m1;
  logic [7:0]    cols_m1;
  logic          last_col;

  // Bitmap
  logic          mem [MAX_CELLS];
  logic          mem_q;
  logic [AW-1:0] ra, wa;
  logic          we, wd;
  logic [AW-1:0] clr_q;

  // Results
  logic [13:0] count_q;
  logic        found_q;
  logic [5:0]  rmin_q, rmax_q;
  logic [6:0]  cmin_q, cmax_q;
  logic [2:0]  pidx_q;
  logic [4:0]  nb_q;
  logic        pin_q;
  ssm_pkg::status_e status_q, dec_status;
  ssm_pkg::dec_e    dec;

  // Decision signals
  logic        oob_sel, oob_cell, repeat_sel;
  logic [12:0] anch_n, fin_n;

  // Redraw target
  logic [AXW-1:0] pa_x, lo_x, hi_x;
  logic [12:0]    r0, r1, c0, c1;
  logic           want;

  // Probe address
  logic [14:0] paddr;
  logic        pin;

  // Flags
  logic [6:0] flags;

  assign prod    = g_rows_q * g_cols_q;
  assign cols_x  = {5'd0, g_cols_q};
  assign rows_m1 = g_rows_q - 7'd1;
  assign cols_m1 = g_cols_q - 8'd1;
  assign last_col = (sw_c_q == cols_m1[6:0]);

  // Request checks
  assign oob_sel    = ({1'b0, sa_q} >= len_q) || ({1'b0, ea_q} >= len_q);
  assign oob_cell   = ({1'b0, ca_q} >= len_q);
  assign repeat_sel = (sa_q == anchor_q) && (ea_q == final_q) && has_sel_q;

  always_comb begin
    dec        = ssm_pkg::DEC_FINISH;
    dec_status = ssm_pkg::ST_DONE;
    unique case (req_q)
      ssm_pkg::REQ_SELECT: begin
        if (oob_sel) dec_status = ssm_pkg::ST_OUT_OF_SCREEN;
        else if (repeat_sel) dec_status = ssm_pkg::ST_UNCHANGED;
        else dec = ssm_pkg::DEC_REDRAW;
      end
      ssm_pkg::REQ_MODE: begin
        if (has_sel_q) dec = ssm_pkg::DEC_REDRAW;
        else dec_status = ssm_pkg::ST_NO_SEL;
      end
      ssm_pkg::REQ_FLAGS: begin
        if (oob_cell) dec_status = ssm_pkg::ST_OUT_OF_SCREEN;
        else dec = ssm_pkg::DEC_PROBE;
      end
      ssm_pkg::REQ_BOX: begin
        if (!has_sel_q || anchor_q == final_q) dec_status = ssm_pkg::ST_NO_SEL;
        else dec = ssm_pkg::DEC_BOX;
      end
      default: dec = ssm_pkg::DEC_FINISH;
    endcase
  end

  assign anch_n = (req_q == ssm_pkg::REQ_SELECT) ? sa_q : anchor_q;
  assign fin_n  = (req_q == ssm_pkg::REQ_SELECT) ? ea_q : final_q;

  assign ga = (la_rem_q >= cols_x);
  assign gb = (lb_rem_q >= cols_x);
  assign gx = (lx_rem_q >= cols_x);

  // Target value of the cell in the pipe stage
  always_comb begin
    pa_x = AXW'(p_a_q);
    lo_x = AXW'((anchor_q < final_q) ? anchor_q : final_q);
    hi_x = AXW'((anchor_q < final_q) ? final_q : anchor_q);
    r0   = (la_quo_q < lb_quo_q) ? la_quo_q : lb_quo_q;
    r1   = (la_quo_q < lb_quo_q) ? lb_quo_q : la_quo_q;
    c0   = (la_rem_q < lb_rem_q) ? la_rem_q : lb_rem_q;
    c1   = (la_rem_q < lb_rem_q) ? lb_rem_q : la_rem_q;
    if (rect_q) begin
      want = ({7'd0, p_r_q} >= r0) && ({7'd0, p_r_q} <= r1) &&
             ({6'd0, p_c_q} >= c0) && ({6'd0, p_c_q} <= c1);
    end else begin
      want = (pa_x >= lo_x) && (pa_x <= hi_x);
    end
  end

  // Neighbor probe address: cell, left, right, up, down
  always_comb begin
    unique case (pidx_q)
      3'd0:    paddr = {2'd0, ca_q};
      3'd1:    paddr = {2'd0, ca_q} - 15'd1;
      3'd2:    paddr = {2'd0, ca_q} + 15'd1;
      3'd3:    paddr = {2'd0, ca_q} - {7'd0, g_cols_q};
      default: paddr = {2'd0, ca_q} + {7'd0, g_cols_q};
    endcase
    pin = (paddr < {1'b0, len_q});
  end

  // Edge flags of the queried cell
  always_comb begin
    flags = 7'd1;
    if (la_rem_q == lb_rem_q) begin
      flags[1] = 1'b1;
    end else begin
      flags[2] = (lx_rem_q == 13'd0) || !nb_q[1];
      flags[3] = (lx_rem_q == {5'd0, cols_m1}) || !nb_q[2];
    end
    if (la_quo_q == lb_quo_q) begin
      flags[4] = 1'b1;
    end else begin
      flags[5] = (lx_quo_q == 13'd0) || !nb_q[3];
      flags[6] = (lx_quo_q == {6'd0, rows_m1}) || !nb_q[4];
    end
  end

  // Bitmap port control
  always_comb begin
    ra = cmd_i.probe_issue ? AW'(paddr) : sw_a_q;
    we = 1'b0;
    wa = p_a_q;
    wd = want;
    if (cmd_i.clear) begin
      we = 1'b1;
      wa = clr_q;
      wd = 1'b0;
    end else if (p_valid_q && req_q != ssm_pkg::REQ_BOX && mem_q != want) begin
      we = 1'b1;
    end
  end

  // Bitmap memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    mem_q <= mem[ra];
  end

  // Configuration and selection state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= ssm_pkg::RowsReset;
      cols_cfg_q <= ssm_pkg::ColsReset;
      anchor_q   <= '0;
      final_q    <= '0;
      has_sel_q  <= 1'b0;
      rect_q     <= 1'b0;
      clr_q      <= '0;
      p_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == ssm_pkg::CFG_ROWS) rows_cfg_q <= cfg_data_i[6:0];
        else cols_cfg_q <= cfg_data_i;
      end
      if (cmd_i.clear) clr_q <= clr_q + AW'(1);
      if (cmd_i.decide) begin
        if (req_q == ssm_pkg::REQ_SELECT && dec == ssm_pkg::DEC_REDRAW) begin
          anchor_q  <= sa_q;
          final_q   <= ea_q;
          rect_q    <= rm_q;
          has_sel_q <= 1'b1;
        end else if (req_q == ssm_pkg::REQ_MODE) begin
          rect_q <= rm_q;
        end
      end
      p_valid_q <= cmd_i.sweep;
      if (cmd_i.finish) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      req_q    <= ssm_pkg::req_e'(req_type_i);
      sa_q     <= start_addr_i;
      ea_q     <= end_addr_i;
      rm_q     <= rect_mode_i;
      ca_q     <= cell_addr_i;
      g_rows_q <= (rows_cfg_q == 7'd0) ? 7'd1 :
                  (rows_cfg_q > ssm_pkg::RowsMax) ? ssm_pkg::RowsMax : rows_cfg_q;
      g_cols_q <= (cols_cfg_q == 8'd0) ? 8'd1 :
                  (cols_cfg_q > ssm_pkg::ColsMax) ? ssm_pkg::ColsMax : cols_cfg_q;
    end
    // Cut rows until the screen fits the bitmap
    if (cmd_i.geom) begin
      len_q <= prod[13:0];
      if (sts_o.geom_over) g_rows_q <= g_rows_q - 7'd1;
    end
    if (cmd_i.decide) begin
      status_q <= dec_status;
      la_rem_q <= anch_n;
      lb_rem_q <= fin_n;
      lx_rem_q <= ca_q;
      la_quo_q <= '0;
      lb_quo_q <= '0;
      lx_quo_q <= '0;
      sw_r_q   <= '0;
      sw_c_q   <= '0;
      sw_a_q   <= '0;
      count_q  <= '0;
      found_q  <= 1'b0;
      pidx_q   <= '0;
    end
    // Row and column of each address by repeated subtraction
    if (cmd_i.locate) begin
      if (ga) begin
        la_rem_q <= la_rem_q - cols_x;
        la_quo_q <= la_quo_q + 13'd1;
      end
      if (gb) begin
        lb_rem_q <= lb_rem_q - cols_x;
        lb_quo_q <= lb_quo_q + 13'd1;
      end
      if (gx) begin
        lx_rem_q <= lx_rem_q - cols_x;
        lx_quo_q <= lx_quo_q + 13'd1;
      end
    end
    // Sweep issue stage
    if (cmd_i.sweep) begin
      p_r_q  <= sw_r_q;
      p_c_q  <= sw_c_q;
      p_a_q  <= sw_a_q;
      sw_a_q <= sw_a_q + AW'(1);
      if (last_col) begin
        sw_c_q <= '0;
        sw_r_q <= sw_r_q + 6'd1;
      end else begin
        sw_c_q <= sw_c_q + 7'd1;
      end
    end
    // Sweep update stage
    if (p_valid_q) begin
      if (req_q == ssm_pkg::REQ_BOX) begin
        if (mem_q) begin
          found_q <= 1'b1;
          if (!found_q || p_r_q < rmin_q) rmin_q <= p_r_q;
          if (!found_q || p_r_q > rmax_q) rmax_q <= p_r_q;
          if (!found_q || p_c_q < cmin_q) cmin_q <= p_c_q;
          if (!found_q || p_c_q > cmax_q) cmax_q <= p_c_q;
        end
      end else if (mem_q != want) begin
        count_q <= count_q + 14'd1;
      end
    end
    // Neighbor probes
    if (cmd_i.probe_issue) pin_q <= pin;
    if (cmd_i.probe_cap) begin
      nb_q[pidx_q] <= pin_q & mem_q;
      pidx_q       <= pidx_q + 3'd1;
    end
    // Result register
    if (cmd_i.finish) begin
      status_o        <= status_q;
      changed_count_o <= count_q;
      cell_flags_o    <= '0;
      box_row_o       <= '0;
      box_col_o       <= '0;
      box_width_o     <= '0;
      box_height_o    <= '0;
      if (req_q == ssm_pkg::REQ_FLAGS && status_q == ssm_pkg::ST_DONE && nb_q[0]) begin
        cell_flags_o <= flags;
      end
      if (req_q == ssm_pkg::REQ_BOX && status_q == ssm_pkg::ST_DONE) begin
        if (found_q) begin
          box_row_o    <= rmin_q;
          box_col_o    <= cmin_q;
          box_width_o  <= {1'b0, cmax_q} - {1'b0, cmin_q} + 8'd1;
          box_height_o <= {1'b0, rmax_q} - {1'b0, rmin_q} + 7'd1;
        end else begin
          status_o <= ssm_pkg::ST_NO_SEL;
        end
      end
    end
  end

  // Status to the controller
  always_comb begin
    sts_o.dec        = dec;
    sts_o.geom_over  = (32'(prod) > MAX_CELLS);
    sts_o.loc_done   = !ga && !gb && !gx;
    sts_o.sweep_last = (sw_r_q == rows_m1[5:0]) && last_col;
    sts_o.clear_last = (clr_q == AW'(MAX_CELLS - 1));
    sts_o.probe_last = (pidx_q == 3'd4);
    sts_o.out_free   = !out_valid_o || out_ready_i;
  end

endmodule

/* design/screen_selection_marker.sv */
// ----------------------------------------------------------------------------
// screen_selection_marker
// Selection bitmap of a character screen with select, mode and query requests.
// ----------------------------------------------------------------------------
// Operation: a geometry fit first; then a select or mode redraw locates its
//   addresses and sweeps the bitmap (one bitmap cell per cycle), a box query
//   sweeps it without a locate, a flags query locates and probes the cell.
// Requests are served one at a time.
// Reset: a clearing pass zeroes the bitmap; s_axis_tready
//   stays low until it ends. Geometry resets to 24 rows by 80 columns.
module screen_selection_marker #(
  parameter int MAX_CELLS = ssm_pkg::MaxCellsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // start_addr[12:0], end_addr[25:13], rect_mode[26], cell_addr[39:27]
  input  logic [39:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], changed_count[15:2], cell_flags[22:16], box_row[28:23],
  // box_col[35:29], box_width[43:36], box_height[50:44], zero[55:51]
  output logic [55:0] m_axis_tdata
);

  ssm_pkg::cmd_t cmd;
  ssm_pkg::sts_t sts;

  ssm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign m_axis_tdata[55:51] = '0;

  ssm_datapath #(
    .MAX_CELLS (MAX_CELLS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (s_axis_tuser),
    .start_addr_i    (s_axis_tdata[12:0]),
    .end_addr_i      (s_axis_tdata[25:13]),
    .rect_mode_i     (s_axis_tdata[26]),
    .cell_addr_i     (s_axis_tdata[39:27]),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .status_o        (m_axis_tdata[1:0]),
    .changed_count_o (m_axis_tdata[15:2]),
    .cell_flags_o    (m_axis_tdata[22:16]),
    .box_row_o       (m_axis_tdata[28:23]),
    .box_col_o       (m_axis_tdata[35:29]),
    .box_width_o     (m_axis_tdata[43:36]),
    .box_height_o    (m_axis_tdata[50:44])
  );

endmodule

/* design/ssm_checker.sv */
// ----------------------------------------------------------------------------
// ssm_checker
// Port-level checks of the screen selection marker results.
// ----------------------------------------------------------------------------
module ssm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Flipped cells are only reported for a completed request
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] != 2'd0 |-> m_axis_tdata[15:2] == 14'd0)
    else $error("count on a rejected request");

  // Any edge flag implies the active flag
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[22:16] != 7'd0 |-> m_axis_tdata[16])
    else $error("edge flag without active flag");

  // Box width and height are zero together
  a_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[43:36] == 8'd0) == (m_axis_tdata[50:44] == 7'd0))
    else $error("half-empty bounding box");

endmodule

bind screen_selection_marker ssm_checker u_ssm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* tb/screen_selection_marker_test.sv */
// ----------------------------------------------------------------------------
// screen_selection_marker_test
// Self-checking bench for the screen selection marker. A behavioral bitmap
// model predicts status, changed count, edge flags and bounding box for each
// request. It walks a directed table first and then random select, mode and
// query sequences over several screen geometries, with random idling on both
// stream sides.
// ----------------------------------------------------------------------------
module screen_selection_marker_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = 8192;
  localparam int STALL_LIMIT = 200000;

  // Lowest field in the lowest bits, matching m_axis_tdata
  typedef struct packed {
    logic [6:0]  bh;
    logic [7:0]  bw;
    logic [6:0]  bcol;
    logic [5:0]  brow;
    logic [6:0]  flags;
    logic [13:0] count;
    logic [1:0]  status;
  } result_t;

  typedef struct {
    ssm_pkg::req_e kind;
    logic [12:0]   sa;
    logic [12:0]   ea;
    logic          rm;
    logic [12:0]   ca;
    logic          typed;
    result_t       want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = ssm_pkg::CFG_ROWS;
  logic [7:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = ssm_pkg::REQ_SELECT;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  screen_selection_marker dut (.*);

  always #10 clk_i = ~clk_i;

  // Predictor state
  bit          sel_map[CELLS];
  int unsigned anchor_q, final_q, rows_reg, cols_reg, g_rows, g_cols, g_len;
  bit          have_sel, rect_on;
  result_t     expected_q[$];

  int errors, sent, got, stall_cnt;
  int src_idle, snk_idle;
  bit snk_hold;

  task automatic report(input string what, input int unsigned seen, exp_v);
    errors++;
    $display("mismatch @%0t result %0d: %s got %0d expected %0d",
             $time, got, what, seen, exp_v);
  endtask

  function automatic void fit_geometry();
    int unsigned r, c;
    r = rows_reg; c = cols_reg;
    if (r < 1) r = 1;
    if (r > 64) r = 64;
    if (c < 1) c = 1;
    if (c > 128) c = 128;
    if (r * c > CELLS) r = CELLS / c;
    g_rows = r; g_cols = c; g_len = r * c;
  endfunction

  function automatic bit cell_on(int a);
    return (a >= 0 && a < g_len) ? sel_map[a] : 1'b0;
  endfunction

  function automatic int unsigned paint();
    int unsigned lo, hi, r0, r1, c0, c1, t, n;
    bit want;
    lo = anchor_q; hi = final_q; n = 0;
    if (lo > hi) begin t = lo; lo = hi; hi = t; end
    r0 = lo / g_cols; r1 = hi / g_cols; c0 = lo % g_cols; c1 = hi % g_cols;
    if (c0 > c1) begin t = c0; c0 = c1; c1 = t; end
    for (int unsigned a = 0; a < g_len; a++) begin
      if (rect_on)
        want = (a / g_cols >= r0) && (a / g_cols <= r1) &&
               (a % g_cols >= c0) && (a % g_cols <= c1);
      else
        want = (a >= lo) && (a <= hi);
      if (sel_map[a] != want) begin sel_map[a] = want; n++; end
    end
    return n;
  endfunction

  function automatic result_t serve(ssm_pkg::req_e kind, int unsigned sa, ea, bit rm,
                                    int unsigned ca);
    result_t res;
    int unsigned row, col, rmin, cmin, rmax, cmax, n;
    res = '0;
    fit_geometry();
    case (kind)
      ssm_pkg::REQ_SELECT: begin
        if (sa >= g_len || ea >= g_len) res.status = ssm_pkg::ST_OUT_OF_SCREEN;
        else if (sa == anchor_q && ea == final_q && have_sel)
          res.status = ssm_pkg::ST_UNCHANGED;
        else begin
          anchor_q = sa; final_q = ea; rect_on = rm;
          res.count = paint();
          have_sel = 1'b1;
        end
      end
      ssm_pkg::REQ_MODE: begin
        rect_on = rm;
        if (have_sel) res.count = paint();
        else res.status = ssm_pkg::ST_NO_SEL;
      end
      ssm_pkg::REQ_FLAGS: begin
        if (ca >= g_len) res.status = ssm_pkg::ST_OUT_OF_SCREEN;
        else if (sel_map[ca]) begin
          row = ca / g_cols; col = ca % g_cols;
          res.flags = 7'd1;
          if (anchor_q % g_cols == final_q % g_cols) res.flags[1] = 1'b1;
          else begin
            if (col == 0 || !cell_on(int'(ca) - 1)) res.flags[2] = 1'b1;
            if (col == g_cols - 1 || !cell_on(int'(ca) + 1)) res.flags[3] = 1'b1;
          end
          if (anchor_q / g_cols == final_q / g_cols) res.flags[4] = 1'b1;
          else begin
            if (row == 0 || !cell_on(int'(ca) - int'(g_cols))) res.flags[5] = 1'b1;
            if (row == g_rows - 1 || !cell_on(int'(ca + g_cols))) res.flags[6] = 1'b1;
          end
        end
      end
      default: begin
        if (!have_sel || anchor_q == final_q) res.status = ssm_pkg::ST_NO_SEL;
        else begin
          rmin = g_rows; cmin = g_cols; rmax = 0; cmax = 0; n = 0;
          for (int unsigned a = 0; a < g_len; a++)
            if (sel_map[a]) begin
              n++; row = a / g_cols; col = a % g_cols;
              if (row < rmin) rmin = row;
              if (col < cmin) cmin = col;
              if (row > rmax) rmax = row;
              if (col > cmax) cmax = col;
            end
          if (n == 0) res.status = ssm_pkg::ST_NO_SEL;
          else begin
            res.brow = rmin; res.bcol = cmin;
            res.bw = cmax - cmin + 1; res.bh = rmax - rmin + 1;
          end
        end
      end
    endcase
    return res;
  endfunction

  // Offer one request and wait for its transfer; valid stays up for a follow-on
  task automatic send(row_t it);
    result_t exp_r;
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.kind;
    s_axis_tdata  <= {it.ca, it.rm, it.ea, it.sa};
    do @(posedge clk_i); while (!s_axis_tready);
    exp_r = serve(it.kind, it.sa, it.ea, it.rm, it.ca);
    if (it.typed && exp_r != it.want) begin
      errors++;
      $display("directed row %0d disagrees with predictor", sent);
    end
    expected_q.push_back(exp_r);
    sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_reg(logic idx, int unsigned v);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= v[7:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == ssm_pkg::CFG_ROWS) rows_reg = v & 8'h7f;
    else cols_reg = v & 8'hff;
  endtask

  function automatic row_t mk(ssm_pkg::req_e k, int unsigned sa, ea, bit rm,
                              int unsigned ca);
    row_t it;
    it.kind = k; it.sa = sa; it.ea = ea; it.rm = rm; it.ca = ca;
    it.typed = 1'b0; it.want = '0;
    return it;
  endfunction

  function automatic row_t mk_t(ssm_pkg::req_e k, int unsigned sa, ea, bit rm,
                                int unsigned ca, ssm_pkg::status_e st, int unsigned cnt);
    row_t it;
    it = mk(k, sa, ea, rm, ca);
    it.typed = 1'b1; it.want.status = st; it.want.count = cnt;
    return it;
  endfunction

  function automatic int unsigned pick_addr();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 4) return $urandom_range(8191);
    if (p < 8) return g_len - 1 + $urandom_range(1);
    return $urandom_range(g_len - 1);
  endfunction

  // Random request mix: mostly selects followed by queries on live cells
  task automatic random_run(int n);
    int unsigned p, sa, ea;
    for (int i = 0; i < n; i++) begin
      fit_geometry();
      p = $urandom_range(99);
      if (p < 40) send(mk(ssm_pkg::REQ_SELECT, pick_addr(), pick_addr(),
                          $urandom_range(1), 0));
      else if (p < 45) send(mk(ssm_pkg::REQ_SELECT, anchor_q, final_q,
                               $urandom_range(1), 0));
      else if (p < 55) send(mk(ssm_pkg::REQ_MODE, $urandom_range(8191),
                               $urandom_range(8191), $urandom_range(1),
                               $urandom_range(8191)));
      else if (p < 85) begin
        sa = anchor_q < final_q ? anchor_q : final_q;
        ea = anchor_q < final_q ? final_q : anchor_q;
        send(mk(ssm_pkg::REQ_FLAGS, $urandom, $urandom, $urandom_range(1),
                ($urandom_range(3) == 0) ? pick_addr() : $urandom_range(ea, sa)));
      end else send(mk(ssm_pkg::REQ_BOX, $urandom, $urandom, $urandom_range(1),
                       $urandom));
    end
  endtask

  // Result checking
  always @(posedge clk_i) begin
    result_t seen, exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      seen = m_axis_tdata[50:0];
      got++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("unexpected result @%0t", $time);
      end else begin
        exp_r = expected_q.pop_front();
        if (seen.status != exp_r.status) report("status", seen.status, exp_r.status);
        if (seen.count != exp_r.count) report("changed_count", seen.count, exp_r.count);
        if (seen.flags != exp_r.flags) report("cell_flags", seen.flags, exp_r.flags);
        if (seen.brow != exp_r.brow) report("box_row", seen.brow, exp_r.brow);
        if (seen.bcol != exp_r.bcol) report("box_col", seen.bcol, exp_r.bcol);
        if (seen.bw != exp_r.bw) report("box_width", seen.bw, exp_r.bw);
        if (seen.bh != exp_r.bh) report("box_height", seen.bh, exp_r.bh);
        if (m_axis_tdata[55:51] != '0) report("pad bits", m_axis_tdata[55:51], 0);
      end
    end
  end

  // Receiver readiness
  always @(posedge clk_i)
    m_axis_tready <= !snk_hold && ($urandom_range(99) >= snk_idle);

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt > STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    row_t dir_tab[$];
    rows_reg = 24; cols_reg = 80;
    src_idle = 0; snk_idle = 0; snk_hold = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at the default 24x80 screen
    dir_tab.push_back(mk_t(ssm_pkg::REQ_MODE, 0, 0, 1'b1, 0, ssm_pkg::ST_NO_SEL, 0));
    dir_tab.push_back(mk_t(ssm_pkg::REQ_BOX, 0, 0, 1'b0, 0, ssm_pkg::ST_NO_SEL, 0));
    dir_tab.push_back(mk_t(ssm_pkg::REQ_FLAGS, 0, 0, 1'b0, 0, ssm_pkg::ST_DONE, 0));
    dir_tab.push_back(mk_t(ssm_pkg::REQ_FLAGS, 0, 0, 1'b0, 8191,
                           ssm_pkg::ST_OUT_OF_SCREEN, 0));
    dir_tab.push_back(mk_t(ssm_pkg::REQ_SELECT, 1920, 0, 1'b0, 0,
                           ssm_pkg::ST_OUT_OF_SCREEN, 0));
    dir_tab.push_back(mk_t(ssm_pkg::REQ_SELECT, 0, 8191, 1'b1, 0,
                           ssm_pkg::ST_OUT_OF_SCREEN, 0));
    dir_tab.push_back(mk_t(ssm_pkg::REQ_SELECT, 0, 0, 1'b0, 0, ssm_pkg::ST_DONE, 1));
    dir_tab.push_back(mk_t(ssm_pkg::REQ_BOX, 0, 0, 1'b0, 0, ssm_pkg::ST_NO_SEL, 0));
    dir_tab.push_back(mk_t(ssm_pkg::REQ_SELECT, 0, 0, 1'b1, 0,
                           ssm_pkg::ST_UNCHANGED, 0));
    dir_tab.push_back(mk_t(ssm_pkg::REQ_SELECT, 1919, 0, 1'b0, 0,
                           ssm_pkg::ST_DONE, 1919));
    dir_tab.push_back(mk(ssm_pkg::REQ_FLAGS, 0, 0, 1'b0, 1919));
    dir_tab.push_back(mk(ssm_pkg::REQ_BOX, 0, 0, 1'b0, 0));
    dir_tab.push_back(mk(ssm_pkg::REQ_SELECT, 85, 250, 1'b1, 0));
    dir_tab.push_back(mk(ssm_pkg::REQ_FLAGS, 0, 0, 1'b0, 85));
    dir_tab.push_back(mk(ssm_pkg::REQ_FLAGS, 0, 0, 1'b0, 250));
    dir_tab.push_back(mk(ssm_pkg::REQ_BOX, 0, 0, 1'b0, 0));
    dir_tab.push_back(mk(ssm_pkg::REQ_MODE, 0, 0, 1'b0, 0));
    dir_tab.push_back(mk(ssm_pkg::REQ_MODE, 0, 0, 1'b1, 0));
    dir_tab.push_back(mk(ssm_pkg::REQ_SELECT, 300, 90, 1'b1, 0));
    dir_tab.push_back(mk(ssm_pkg::REQ_FLAGS, 0, 0, 1'b0, 170));
    dir_tab.push_back(mk(ssm_pkg::REQ_SELECT, 5, 1605, 1'b1, 0));
    dir_tab.push_back(mk(ssm_pkg::REQ_FLAGS, 0, 0, 1'b0, 805));
    dir_tab.push_back(mk(ssm_pkg::REQ_BOX, 0, 0, 1'b0, 0));
    foreach (dir_tab[i]) send(dir_tab[i]);
    drain();

    // Phase 1: sender idles lightly, receiver heavily; small screen
    src_idle = 19; snk_idle = 74;
    set_reg(ssm_pkg::CFG_ROWS, 5); set_reg(ssm_pkg::CFG_COLS, 7);
    random_run(60);
    drain();

    // Pause until all results are in, then one column and one row extremes
    set_reg(ssm_pkg::CFG_ROWS, 64); set_reg(ssm_pkg::CFG_COLS, 1);
    random_run(25);
    drain();
    set_reg(ssm_pkg::CFG_ROWS, 1); set_reg(ssm_pkg::CFG_COLS, 128);
    random_run(25);
    drain();

    // Phase 2: roles swapped; out-of-range settings saturate
    src_idle = 74; snk_idle = 19;
    set_reg(ssm_pkg::CFG_ROWS, 0); set_reg(ssm_pkg::CFG_COLS, 0);
    random_run(15);
    drain();
    set_reg(ssm_pkg::CFG_ROWS, 127); set_reg(ssm_pkg::CFG_COLS, 255);
    random_run(6);
    drain();
    set_reg(ssm_pkg::CFG_ROWS, 9); set_reg(ssm_pkg::CFG_COLS, 12);
    random_run(60);
    drain();

    // Phase 3: no idling, long receiver hold-off while requests keep coming
    src_idle = 0; snk_idle = 0;
    set_reg(ssm_pkg::CFG_ROWS, 4); set_reg(ssm_pkg::CFG_COLS, 16);
    fork
      begin
        snk_hold = 1'b1;
        repeat (3000) @(posedge clk_i);
        snk_hold = 1'b0;
      end
      random_run(80);
    join
    drain();

    repeat (50) @(posedge clk_i);
    $display("covered %0d requests, %0d results over eight screen geometries", sent, got);
    $display("selects, mode redraws, flag and box queries with both sides stalling");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
